@@ rtl/core/c8ie_pkg.sv @@
// Shared types and constants of the CHIP-8 instruction executor.
package c8ie_pkg;

	localparam int STACK_DEPTH_DEF  = 16;
	localparam int MEMORY_BYTES_DEF = 4096;
	localparam int FONT_BASE_DEF    = 0;

	localparam logic [11:0] START_PC_RST = 12'd512;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_START_PC = 1'b0;

	localparam logic [15:0] W_CLS = 16'h00E0;
	localparam logic [15:0] W_RET = 16'h00EE;

	localparam logic [7:0] KK_SKP  = 8'h9E;
	localparam logic [7:0] KK_SKNP = 8'hA1;
	localparam logic [7:0] KK_GDT  = 8'h07;
	localparam logic [7:0] KK_WKEY = 8'h0A;
	localparam logic [7:0] KK_SDT  = 8'h15;
	localparam logic [7:0] KK_SST  = 8'h18;
	localparam logic [7:0] KK_ADDI = 8'h1E;
	localparam logic [7:0] KK_FONT = 8'h29;
	localparam logic [7:0] KK_BCD  = 8'h33;
	localparam logic [7:0] KK_SAVE = 8'h55;
	localparam logic [7:0] KK_REST = 8'h65;

	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	typedef enum logic [1:0] {ST_OK, ST_FAIL, ST_UNKNOWN} status_t;
	typedef enum logic [1:0] {DRAW_NONE, DRAW_CLS, DRAW_ROW} draw_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_CAPTURE, CMD_LOAD_MEM, CMD_READ_X, CMD_READ_Y, CMD_EXEC,
		CMD_FLAG, CMD_BCD, CMD_MOVE_RD, CMD_MOVE_WR, CMD_FINISH, CMD_ROW_RD,
		CMD_EMIT_ROW, CMD_EMIT_ONE
	} cmd_t;

	typedef enum logic [2:0] {K_PLAIN, K_DRAW, K_BCD, K_SAVE, K_RESTORE} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  failed;
		logic  move_end;
		logic  row_ok;
		logic  row_last;
		logic  bcd_last;
		logic  out_free;
	} dp_stat_t;

	typedef struct packed {
		logic        func;
		logic [15:0] instruction_word;
		logic [11:0] load_address;
		logic [7:0]  load_data;
		logic [15:0] keys_pressed;
		logic [7:0]  random_byte;
		logic [3:0]  waited_key;
		logic        collision;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] next_pc;
		draw_t       draw_op;
		logic [7:0]  sprite_x;
		logic [7:0]  sprite_y;
		logic [3:0]  sprite_rows;
		logic [7:0]  row_data;
		logic        last;
		logic [7:0]  sound_timer_value;
	} result_t;

endpackage

@@ rtl/core/c8ie_if.sv @@
// Valid/ready channels for input items and result words.
interface c8ie_cmd_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] instruction_word;
	logic [11:0] load_address;
	logic [7:0]  load_data;
	logic [15:0] keys_pressed;
	logic [7:0]  random_byte;
	logic [3:0]  waited_key;
	logic        collision;

	modport source (output valid, func, instruction_word, load_address, load_data,
		keys_pressed, random_byte, waited_key, collision, input ready);
	modport sink (input valid, func, instruction_word, load_address, load_data,
		keys_pressed, random_byte, waited_key, collision, output ready);
endinterface

interface c8ie_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] next_pc;
	logic [1:0]  draw_op;
	logic [7:0]  sprite_x;
	logic [7:0]  sprite_y;
	logic [3:0]  sprite_rows;
	logic [7:0]  row_data;
	logic        last;
	logic [7:0]  sound_timer_value;

	modport source (output valid, status, next_pc, draw_op, sprite_x, sprite_y,
		sprite_rows, row_data, last, sound_timer_value, input ready);
	modport sink (input valid, status, next_pc, draw_op, sprite_x, sprite_y,
		sprite_rows, row_data, last, sound_timer_value, output ready);
endinterface

@@ rtl/core/c8ie_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module c8ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/c8ie_ctrl.sv @@
// Sequencing state machine of the executor.
module c8ie_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_func,
	output logic               in_ready,
	input  c8ie_pkg::dp_stat_t stat,
	output c8ie_pkg::cmd_t     cmd
);
	import c8ie_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_RDX, S_RDY, S_EXEC, S_FLAG, S_BCD, S_MVRD, S_MVWR,
		S_FIN, S_ROWRD, S_ROWOUT, S_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_IDLE:   cmd = in_valid ? CMD_CAPTURE : CMD_NONE;
			S_LOAD:   cmd = CMD_LOAD_MEM;
			S_RDX:    cmd = CMD_READ_X;
			S_RDY:    cmd = CMD_READ_Y;
			S_EXEC:   cmd = CMD_EXEC;
			S_FLAG:   cmd = CMD_FLAG;
			S_BCD:    cmd = CMD_BCD;
			S_MVRD:   cmd = CMD_MOVE_RD;
			S_MVWR:   cmd = CMD_MOVE_WR;
			S_FIN:    cmd = CMD_FINISH;
			S_ROWRD:  cmd = CMD_ROW_RD;
			S_ROWOUT: cmd = stat.out_free ? CMD_EMIT_ROW : CMD_NONE;
			S_OUT:    cmd = stat.out_free ? CMD_EMIT_ONE : CMD_NONE;
			default:  cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_func ? S_LOAD : S_RDX;
					end
				end
				S_LOAD: state_q <= S_OUT;
				S_RDX:  state_q <= S_RDY;
				S_RDY:  state_q <= S_EXEC;
				S_EXEC: state_q <= S_FLAG;
				S_FLAG: begin
					if (stat.failed) begin
						state_q <= S_FIN;
					end else begin
						case (stat.kind)
							K_BCD:     state_q <= S_BCD;
							K_SAVE:    state_q <= S_MVWR;
							K_RESTORE: state_q <= S_MVRD;
							default:   state_q <= S_FIN;
						endcase
					end
				end
				S_BCD: begin
					if (stat.bcd_last) begin
						state_q <= S_FIN;
					end
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					if (stat.move_end) begin
						state_q <= S_FIN;
					end else if (stat.kind == K_RESTORE) begin
						state_q <= S_MVRD;
					end
				end
				S_FIN: begin
					if (stat.kind == K_DRAW && stat.row_ok) begin
						state_q <= S_ROWRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_ROWRD: state_q <= S_ROWOUT;
				S_ROWOUT: begin
					if (stat.out_free) begin
						state_q <= stat.row_last ? S_IDLE : S_ROWRD;
					end
				end
				S_OUT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/c8ie_dp.sv @@
// Datapath: registers, stack, memory, instruction execution and result register.
module c8ie_dp #(
	parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
	parameter int MEMORY_BYTES = c8ie_pkg::MEMORY_BYTES_DEF,
	parameter int FONT_BASE    = c8ie_pkg::FONT_BASE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  c8ie_pkg::cmd_t      cmd,
	input  c8ie_pkg::item_t     item,
	input  logic                cfg_we,
	input  logic [11:0]         cfg_wdata,
	output logic [11:0]         start_pc,
	input  logic                out_ready,
	output logic                out_valid,
	output c8ie_pkg::result_t   result,
	output c8ie_pkg::dp_stat_t  stat
);
	import c8ie_pkg::*;

	localparam int MEM_AW = $clog2(MEMORY_BYTES);
	localparam int SA_W   = $clog2(STACK_DEPTH);
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam logic [16:0] MEM_END = 17'(MEMORY_BYTES);
	localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

	item_t       it_q;
	logic [7:0]  v_q [16];
	logic [7:0]  vx_q, vy_q;
	logic [15:0] pc_q, i_q;
	logic [7:0]  dt_q, st_q;
	logic [SP_W-1:0] sp_q;
	status_t     status_q;
	logic        skip_q, adv_q, flag_pend_q, flag_q;
	logic [3:0]  idx_q;
	logic [11:0] start_pc_q;
	logic        out_valid_q;
	result_t     res_q;

	logic [15:0] w;
	logic [3:0]  op, x, y, n;
	logic [7:0]  kk;
	logic [11:0] nnn;
	kind_t       kind;

	assign w   = it_q.instruction_word;
	assign op  = w[15:12];
	assign x   = w[11:8];
	assign y   = w[7:4];
	assign n   = w[3:0];
	assign kk  = w[7:0];
	assign nnn = w[11:0];

	always_comb begin
		kind = K_PLAIN;
		if (op == 4'hD) begin
			kind = K_DRAW;
		end else if (op == 4'hF) begin
			case (kk)
				KK_BCD:  kind = K_BCD;
				KK_SAVE: kind = K_SAVE;
				KK_REST: kind = K_RESTORE;
				default: kind = K_PLAIN;
			endcase
		end
	end

	// Register file read port: one address per cycle.
	logic [3:0] rf_ra;
	logic [7:0] rf_rd;
	always_comb begin
		case (cmd)
			CMD_READ_Y:  rf_ra = (op == 4'hB) ? 4'd0 : y;
			CMD_MOVE_WR: rf_ra = idx_q;
			default:     rf_ra = x;
		endcase
	end
	assign rf_rd = v_q[rf_ra];

	// Addresses relative to I.
	logic [16:0] i_idx, i_idx1;
	logic [4:0]  idx1;
	assign i_idx  = {1'b0, i_q} + 17'(idx_q);
	assign i_idx1 = i_idx + 17'd1;
	assign idx1   = {1'b0, idx_q} + 5'd1;

	logic addr_end;
	assign addr_end = (i_idx1 >= MEM_END);

	// BCD digits of Vx.
	logic [1:0]  hund;
	logic [6:0]  rem;
	logic [14:0] tens_prod;
	logic [3:0]  tens, ones;
	logic [7:0]  digit;
	always_comb begin
		if (vx_q >= 8'd200) begin
			hund = 2'd2;
		end else if (vx_q >= 8'd100) begin
			hund = 2'd1;
		end else begin
			hund = 2'd0;
		end
		rem = 7'(vx_q - 8'(hund) * 8'd100);
		tens_prod = 15'(rem) * 15'd205;
		tens = tens_prod[14:11];
		ones = 4'(rem - 7'(tens) * 7'd10);
		case (idx_q[1:0])
			2'd0:    digit = {6'd0, hund};
			2'd1:    digit = {4'd0, tens};
			default: digit = {4'd0, ones};
		endcase
	end

	// Return stack.
	logic              stk_we;
	logic [15:0]       stk_rdata;
	logic [SP_W-1:0]   sp_dec;
	assign sp_dec = sp_q - 1'b1;

	c8ie_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[SA_W-1:0]),
		.wdata (pc_q),
		.re    (cmd == CMD_READ_X),
		.raddr (sp_dec[SA_W-1:0]),
		.rdata (stk_rdata)
	);

	// Main memory.
	logic              mem_we, mem_re;
	logic [MEM_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata, mem_rdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_idx[MEM_AW-1:0];
		mem_wdata = digit;
		case (cmd)
			CMD_LOAD_MEM: begin
				mem_we    = 1'b1;
				mem_waddr = MEM_AW'(it_q.load_address);
				mem_wdata = it_q.load_data;
			end
			CMD_BCD: mem_we = 1'b1;
			CMD_MOVE_WR: begin
				mem_we    = (kind == K_SAVE);
				mem_wdata = rf_rd;
			end
			default: mem_we = 1'b0;
		endcase
	end
	assign mem_re = (cmd == CMD_MOVE_RD) || (cmd == CMD_ROW_RD);

	c8ie_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (i_idx[MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	// Instruction execution, evaluated in the execute cycle.
	status_t     ex_status;
	logic        ex_skip, ex_adv, ex_wr, ex_flag_pend, ex_flag;
	logic [7:0]  ex_wd;
	logic        ex_pc_set, ex_i_set, ex_dt_set, ex_st_set, ex_push, ex_pop;
	logic [15:0] ex_pc, ex_i;
	logic [8:0]  sum9;
	logic        key_ok, pressed;

	assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
	assign key_ok  = (vx_q < 8'd16);
	assign pressed = key_ok && it_q.keys_pressed[vx_q[3:0]];

	always_comb begin
		ex_status    = ST_OK;
		ex_skip      = 1'b0;
		ex_adv       = 1'b1;
		ex_wr        = 1'b0;
		ex_wd        = vy_q;
		ex_flag_pend = 1'b0;
		ex_flag      = 1'b0;
		ex_pc_set    = 1'b0;
		ex_pc        = {4'd0, nnn};
		ex_i_set     = 1'b0;
		ex_i         = {4'd0, nnn};
		ex_dt_set    = 1'b0;
		ex_st_set    = 1'b0;
		ex_push      = 1'b0;
		ex_pop       = 1'b0;
		case (op)
			4'h0: begin
				if (w == W_RET) begin
					if (sp_q != '0) begin
						ex_pop    = 1'b1;
						ex_pc_set = 1'b1;
						ex_pc     = stk_rdata;
					end else begin
						ex_status = ST_FAIL;
					end
				end
			end
			4'h1: begin
				ex_pc_set = 1'b1;
				ex_adv    = 1'b0;
			end
			4'h2: begin
				if (sp_q < SP_FULL) begin
					ex_push   = 1'b1;
					ex_pc_set = 1'b1;
					ex_adv    = 1'b0;
				end else begin
					ex_status = ST_FAIL;
				end
			end
			4'h3: ex_skip = (vx_q == kk);
			4'h4: ex_skip = (vx_q != kk);
			4'h5: begin
				if (n != 4'd0) begin
					ex_status = ST_UNKNOWN;
				end else begin
					ex_skip = (vx_q == vy_q);
				end
			end
			4'h6: begin
				ex_wr = 1'b1;
				ex_wd = kk;
			end
			4'h7: begin
				ex_wr = 1'b1;
				ex_wd = vx_q + kk;
			end
			4'h8: begin
				ex_wr = 1'b1;
				case (n)
					ALU_MOV: ex_wd = vy_q;
					ALU_OR:  ex_wd = vx_q | vy_q;
					ALU_AND: ex_wd = vx_q & vy_q;
					ALU_XOR: ex_wd = vx_q ^ vy_q;
					ALU_ADD: begin
						ex_wd        = sum9[7:0];
						ex_flag_pend = 1'b1;
						ex_flag      = sum9[8];
					end
					ALU_SUB: begin
						ex_wd        = vx_q - vy_q;
						ex_flag_pend = 1'b1;
						ex_flag      = (vx_q >= vy_q);
					end
					ALU_SHR: begin
						ex_wd        = {1'b0, vx_q[7:1]};
						ex_flag_pend = 1'b1;
						ex_flag      = vx_q[0];
					end
					ALU_SUBN: begin
						ex_wd        = vy_q - vx_q;
						ex_flag_pend = 1'b1;
						ex_flag      = (vy_q >= vx_q);
					end
					ALU_SHL: begin
						ex_wd        = {vx_q[6:0], 1'b0};
						ex_flag_pend = 1'b1;
						ex_flag      = vx_q[7];
					end
					default: begin
						ex_wr     = 1'b0;
						ex_status = ST_UNKNOWN;
					end
				endcase
			end
			4'h9: begin
				if (n != 4'd0) begin
					ex_status = ST_UNKNOWN;
				end else begin
					ex_skip = (vx_q != vy_q);
				end
			end
			4'hA: ex_i_set = 1'b1;
			4'hB: begin
				// Vy was read from V0 for this opcode.
				ex_pc_set = 1'b1;
				ex_pc     = {4'd0, nnn} + {8'd0, vy_q};
				ex_adv    = 1'b0;
			end
			4'hC: begin
				ex_wr = 1'b1;
				ex_wd = it_q.random_byte & kk;
			end
			4'hD: begin
				ex_flag_pend = 1'b1;
				ex_flag      = it_q.collision;
			end
			4'hE: begin
				case (kk)
					KK_SKP:  ex_skip = pressed;
					KK_SKNP: ex_skip = key_ok && !pressed;
					default: ex_status = ST_UNKNOWN;
				endcase
			end
			default: begin
				case (kk)
					KK_GDT: begin
						ex_wr = 1'b1;
						ex_wd = dt_q;
					end
					KK_WKEY: begin
						ex_wr = 1'b1;
						ex_wd = {4'd0, it_q.waited_key};
					end
					KK_SDT: ex_dt_set = 1'b1;
					KK_SST: ex_st_set = 1'b1;
					KK_ADDI: begin
						ex_i_set = 1'b1;
						ex_i     = i_q + {8'd0, vx_q};
					end
					KK_FONT: begin
						ex_i_set = key_ok;
						ex_i     = 16'(FONT_BASE) +
							16'(7'({vx_q[3:0], 2'b00}) + 7'(vx_q[3:0]));
					end
					KK_BCD: begin
						if (({1'b0, i_q} + 17'd2) >= MEM_END) begin
							ex_status = ST_FAIL;
						end
					end
					KK_SAVE, KK_REST: begin
						if ({1'b0, i_q} >= MEM_END) begin
							ex_status = ST_FAIL;
						end
					end
					default: ex_status = ST_UNKNOWN;
				endcase
			end
		endcase
	end

	assign stk_we = (cmd == CMD_EXEC) && ex_push;

	// Result word assembly.
	logic    out_load;
	result_t res_next;
	assign out_load = (cmd == CMD_EMIT_ROW) || (cmd == CMD_EMIT_ONE);

	always_comb begin
		res_next.status            = status_q;
		res_next.next_pc           = pc_q;
		res_next.draw_op           = DRAW_NONE;
		res_next.sprite_x          = 8'd0;
		res_next.sprite_y          = 8'd0;
		res_next.sprite_rows       = 4'd0;
		res_next.row_data          = 8'd0;
		res_next.last              = 1'b1;
		res_next.sound_timer_value = st_q;
		if (cmd == CMD_EMIT_ROW) begin
			res_next.status      = ST_OK;
			res_next.draw_op     = DRAW_ROW;
			res_next.sprite_x    = vx_q;
			res_next.sprite_y    = vy_q;
			res_next.sprite_rows = n;
			res_next.row_data    = mem_rdata;
			res_next.last        = stat.row_last;
		end else if (it_q.func) begin
			res_next.status = ST_OK;
		end else if (kind == K_DRAW) begin
			res_next.draw_op     = DRAW_ROW;
			res_next.sprite_x    = vx_q;
			res_next.sprite_y    = vy_q;
			res_next.sprite_rows = n;
		end else if (w == W_CLS) begin
			res_next.draw_op = DRAW_CLS;
		end
	end

	assign stat.kind     = kind;
	assign stat.failed   = (status_q != ST_OK);
	assign stat.move_end = (idx_q == x) || addr_end;
	assign stat.row_ok   = ({1'b0, idx_q} < {1'b0, n}) && (i_idx < MEM_END);
	assign stat.row_last = !((idx1 < {1'b0, n}) && (i_idx1 < MEM_END));
	assign stat.bcd_last = (idx_q == 4'd2);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign result    = res_q;
	assign start_pc  = start_pc_q;

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_CAPTURE: it_q <= item;
			CMD_READ_X:  vx_q <= rf_rd;
			CMD_READ_Y:  vy_q <= rf_rd;
			CMD_EXEC: begin
				skip_q <= ex_skip;
				adv_q  <= ex_adv;
				flag_q <= ex_flag;
			end
			default: ;
		endcase
		if (out_load) begin
			res_q <= res_next;
		end
	end

	// Architectural and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				v_q[k] <= 8'd0;
			end
			pc_q        <= {4'd0, START_PC_RST};
			start_pc_q  <= START_PC_RST;
			i_q         <= 16'd0;
			dt_q        <= 8'd0;
			st_q        <= 8'd0;
			sp_q        <= '0;
			status_q    <= ST_OK;
			flag_pend_q <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd)
				CMD_CAPTURE: begin
					status_q <= ST_OK;
					idx_q    <= 4'd0;
				end
				CMD_EXEC: begin
					status_q    <= ex_status;
					flag_pend_q <= ex_flag_pend;
					idx_q       <= 4'd0;
					if (ex_wr) begin
						v_q[x] <= ex_wd;
					end
					if (ex_pc_set) begin
						pc_q <= ex_pc;
					end
					if (ex_i_set) begin
						i_q <= ex_i;
					end
					if (ex_dt_set) begin
						dt_q <= vx_q;
					end
					if (ex_st_set) begin
						st_q <= vx_q;
					end
					if (ex_push) begin
						sp_q <= sp_q + 1'b1;
					end else if (ex_pop) begin
						sp_q <= sp_dec;
					end
				end
				CMD_FLAG: begin
					if (flag_pend_q) begin
						v_q[15] <= {7'd0, flag_q};
					end
				end
				CMD_BCD: idx_q <= idx_q + 4'd1;
				CMD_MOVE_WR: begin
					if (kind == K_RESTORE) begin
						v_q[idx_q] <= mem_rdata;
					end
					if (addr_end) begin
						status_q <= ST_FAIL;
					end
					idx_q <= idx_q + 4'd1;
				end
				CMD_FINISH: begin
					if (status_q == ST_OK && adv_q) begin
						pc_q <= pc_q + (skip_q ? 16'd4 : 16'd2);
					end
				end
				CMD_EMIT_ROW: idx_q <= idx_q + 4'd1;
				default: ;
			endcase
			if (cfg_we) begin
				start_pc_q <= cfg_wdata;
				pc_q       <= {4'd0, cfg_wdata};
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/chip8_instruction_executor.sv @@
// Top level of the CHIP-8 instruction executor.
// Input items arrive on the cmd channel: func 0 executes instruction_word,
// func 1 writes load_data to memory at load_address. Each item produces one or
// more result words on the rsp channel; last marks the final word of the item.
// A draw gives one word per sprite row read from memory, or one word when no
// row is read, and the collision bit carried by the item is written to VF.
// Items are handled one at a time by a state machine stepping a register file
// with a single read port and a memory with one registered read port. A memory
// write stores the byte and emits its word. An instruction reads Vx, then Vy,
// executes and sets VF where it has a flag; BCD then writes its three digits,
// a save writes one register at a time, a restore reads a byte and then writes
// it to a register; the instruction then finishes, and a draw reads each sprite
// row and emits it. The last word of an item becomes valid as the next can be taken.
// Results sit in an output register; when the receiver stalls, the block
// finishes the current item up to its next word and then waits.
// Reset clears V0-VF, I, the timers and the stack pointer and loads the
// program counter with start_pc (512); stack and memory contents are not
// cleared. Writing start_pc over the APB port also loads the program counter.
module chip8_instruction_executor #(
	parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
	parameter int MEMORY_BYTES = c8ie_pkg::MEMORY_BYTES_DEF,
	parameter int FONT_BASE    = c8ie_pkg::FONT_BASE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	c8ie_cmd_if.sink                     cmd,
	c8ie_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [c8ie_pkg::PADDR_W-1:0] paddr,
	input  logic [c8ie_pkg::PDATA_W-1:0] pwdata,
	output logic [c8ie_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import c8ie_pkg::*;

	cmd_t     dp_cmd;
	dp_stat_t dp_stat;
	item_t    item;
	result_t  result;
	logic     out_valid;
	logic     cfg_we;
	logic [11:0] start_pc;
	logic     reg_hit;

	assign reg_hit = (paddr[PADDR_W-1:2] == REG_START_PC);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(PDATA_W-12){1'b0}}, start_pc} : '0;

	assign item.func             = cmd.func;
	assign item.instruction_word = cmd.instruction_word;
	assign item.load_address     = cmd.load_address;
	assign item.load_data        = cmd.load_data;
	assign item.keys_pressed     = cmd.keys_pressed;
	assign item.random_byte      = cmd.random_byte;
	assign item.waited_key       = cmd.waited_key;
	assign item.collision        = cmd.collision;

	c8ie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_func  (cmd.func),
		.in_ready (cmd.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	c8ie_dp #(
		.STACK_DEPTH  (STACK_DEPTH),
		.MEMORY_BYTES (MEMORY_BYTES),
		.FONT_BASE    (FONT_BASE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[11:0]),
		.start_pc  (start_pc),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.result    (result),
		.stat      (dp_stat)
	);

	assign rsp.valid             = out_valid;
	assign rsp.status            = result.status;
	assign rsp.next_pc           = result.next_pc;
	assign rsp.draw_op           = result.draw_op;
	assign rsp.sprite_x          = result.sprite_x;
	assign rsp.sprite_y          = result.sprite_y;
	assign rsp.sprite_rows       = result.sprite_rows;
	assign rsp.row_data          = result.row_data;
	assign rsp.last              = result.last;
	assign rsp.sound_timer_value = result.sound_timer_value;
endmodule
